// File: rtl/core/cpdq_pkg.sv
// shared types, constants and helper functions of the cell pair dither quantizer
package cpdq_pkg;

  localparam int ERR_W = 13;
  localparam int WIN = 10;
  localparam int STEPS = 8;
  localparam logic [6:0] LINE_CELLS_RESET = 7'd60;
  localparam int W_RED = 299;
  localparam int W_GREEN = 587;
  localparam int W_BLUE = 114;
  localparam logic [3:0] PAIR_LAST_BACK = 4'd14;
  localparam logic [3:0] PAIR_LAST_FORE = 4'd15;

  typedef logic signed [ERR_W-1:0] comp_t;
  typedef logic signed [8:0] diff_t;
  typedef logic signed [9:0] rnd_t;
  typedef logic [0:2][7:0] rgb_t;

  localparam rgb_t PALETTE [16] = '{
    24'h000000, 24'h555555, 24'h0000aa, 24'h5555ff,
    24'h00aa00, 24'h55ff55, 24'h00aaaa, 24'h55ffff,
    24'haa0000, 24'hff5555, 24'haa00aa, 24'hff55ff,
    24'haa5500, 24'hffff55, 24'haaaaaa, 24'hffffff
  };

  typedef struct packed {
    logic       pix_we;
    logic [2:0] pix_pos;
    logic       load_shift;
    logic       trial_init;
    logic       ph0;
    logic       ph1;
    logic       ph2;
    logic       ph3;
    logic [2:0] rd_pos;
    logic       commit;
    logic [3:0] back;
    logic [3:0] fore;
    logic       best_upd;
    logic       best_first;
    logic       rotate;
    logic       we_a;
    logic       we_b;
    logic       wzero;
    logic       sel;
    logic       out_load;
    logic [5:0] column;
    logic       line_done;
  } cpdq_cmd_t;

  // (e + 8) >> 4 with floor semantics
  function automatic rnd_t cpdq_round16(input comp_t x);
    logic signed [ERR_W:0] t;
    t = (ERR_W+1)'(x) + (ERR_W+1)'(8);
    return rnd_t'(t >>> 4);
  endfunction

  function automatic logic [7:0] cpdq_sat8(input logic signed [10:0] t);
    logic [7:0] r;
    if (t < 0) r = 8'd0;
    else if (t > 11'sd255) r = 8'd255;
    else r = t[7:0];
    return r;
  endfunction

  function automatic logic [7:0] cpdq_abs(input diff_t e);
    logic [7:0] r;
    if (e < 0) r = 8'(-e);
    else r = 8'(e);
    return r;
  endfunction

endpackage

// File: rtl/core/cpdq_if.sv
// pixel and cell result channel interfaces
interface cpdq_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       frame_start;
  modport source (output valid, red, green, blue, frame_start, input ready);
  modport sink (input valid, red, green, blue, frame_start, output ready);
endinterface

interface cpdq_cell_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bitmap_byte;
  logic [7:0]  colour_byte;
  logic [5:0]  cell_column;
  logic        line_done;
  logic [28:0] cell_error;
  modport source (output valid, bitmap_byte, colour_byte, cell_column, line_done, cell_error,
                  input ready);
  modport sink (input valid, bitmap_byte, colour_byte, cell_column, line_done, cell_error,
                output ready);
endinterface

// File: rtl/core/cell_pair_dither_quantizer.sv
// a pixel that does not close a cell is only stored; the eighth pixel starts window load,
// a trial pass for each of the 120 colour pairs and one commit pass, each a step per cell
// pixel in phases P0 to P3 on one shared dither unit, then rotation, write-back and result
// a cell that ends a line and a pixel with frame_start add a clearing pass over the
// MAX_LINE_WIDTH + 2 row entries; no new pixel is taken while a cell is in work
// rst (synchronous) clears control state and runs the same clearing pass
module cell_pair_dither_quantizer import cpdq_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 512
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_write,
  input  logic [6:0]   cfg_data,
  cpdq_pixel_if.sink   pixel,
  cpdq_cell_if.source  result
);

  localparam int AW = $clog2(MAX_LINE_WIDTH + 2);

  cpdq_cmd_t     cmd;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  cpdq_ctrl #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(pixel.valid),
    .in_frame_start(pixel.frame_start),
    .in_ready(pixel.ready),
    .out_ready(result.ready),
    .out_valid(result.valid),
    .cmd(cmd),
    .raddr(raddr),
    .waddr(waddr)
  );

  cpdq_datapath #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_datapath (
    .clk(clk),
    .cmd(cmd),
    .raddr(raddr),
    .waddr(waddr),
    .in_red(pixel.red),
    .in_green(pixel.green),
    .in_blue(pixel.blue),
    .bitmap_byte(result.bitmap_byte),
    .colour_byte(result.colour_byte),
    .cell_column(result.cell_column),
    .line_done(result.line_done),
    .cell_error(result.cell_error)
  );

endmodule

// File: rtl/core/cpdq_ram.sv
// generic simple dual port ram with registered read
module cpdq_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 514,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/cpdq_ctrl.sv
// controller: line bookkeeping, clearing pass, trial and commit sequencing
module cpdq_ctrl import cpdq_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 512,
  localparam int DEPTH = MAX_LINE_WIDTH + 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic [6:0]      cfg_data,
  input  logic            in_valid,
  input  logic            in_frame_start,
  output logic            in_ready,
  input  logic            out_ready,
  output logic            out_valid,
  output cpdq_cmd_t       cmd,
  output logic [AW-1:0]   raddr,
  output logic [AW-1:0]   waddr
);

  localparam int CELLS_MAX = MAX_LINE_WIDTH / 8;
  localparam int CW = (CELLS_MAX > 1) ? $clog2(CELLS_MAX) : 1;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOAD, ST_INIT, ST_P0, ST_P1, ST_P2, ST_P3,
    ST_TEND, ST_ROT, ST_WB, ST_RESULT
  } state_t;

  state_t        state;
  logic [6:0]    line_cells;
  logic [2:0]    sub;
  logic [CW-1:0] proc;
  logic          odd;
  logic          sel;
  logic [AW-1:0] cnt;
  logic [2:0]    step;
  logic [3:0]    back;
  logic [3:0]    fore;
  logic          commit;
  logic          clear_both;
  logic          done_l;
  logic [CW-1:0] column_l;

  logic          acc;
  logic [2:0]    sub_e;
  logic          odd_e;
  logic [CW-1:0] last;
  logic          done_c;
  logic [CW-1:0] psat;
  logic [CW-1:0] col_c;
  logic [3:0]    q;
  logic [3:0]    li;
  logic [AW-1:0] addr;
  logic [CW+5:0] col_ext;
  logic          out_free;

  assign in_ready = (state == ST_IDLE);
  assign acc = in_valid && in_ready;
  assign sub_e = in_frame_start ? 3'd0 : sub;
  assign odd_e = in_frame_start ? 1'b0 : odd;
  assign out_free = !out_valid || out_ready;

  // cells per line clamped to one..max
  always_comb begin
    if (line_cells == 7'd0) last = '0;
    else if (32'(line_cells) > CELLS_MAX) last = CW'(CELLS_MAX - 1);
    else last = CW'(line_cells - 7'd1);
  end

  assign done_c = proc >= last;
  assign psat = done_c ? last : proc;
  assign col_c = odd ? psat : last - psat;

  assign q = cnt[3:0];
  assign li = odd ? q : 4'(WIN - 1) - q;
  assign addr = AW'({column_l, 3'b000}) + AW'(li);
  assign raddr = addr;
  assign waddr = (state == ST_CLEAR) ? cnt : addr;
  assign col_ext = {6'b0, column_l};

  always_comb begin
    cmd = '0;
    cmd.pix_we = acc;
    cmd.pix_pos = odd_e ? sub_e : ~sub_e;
    cmd.rd_pos = odd ? step : ~step;
    cmd.commit = commit;
    cmd.back = back;
    cmd.fore = fore;
    cmd.sel = sel;
    cmd.column = col_ext[5:0];
    cmd.line_done = done_l;
    case (state)
      ST_CLEAR: begin
        cmd.wzero = 1'b1;
        cmd.we_a = clear_both || sel;
        cmd.we_b = clear_both || !sel;
      end
      ST_LOAD: cmd.load_shift = (cnt != '0);
      ST_INIT: cmd.trial_init = 1'b1;
      ST_P0: cmd.ph0 = 1'b1;
      ST_P1: cmd.ph1 = 1'b1;
      ST_P2: cmd.ph2 = 1'b1;
      ST_P3: cmd.ph3 = 1'b1;
      ST_TEND: begin
        cmd.best_upd = 1'b1;
        cmd.best_first = (back == 4'd0) && (fore == 4'd1);
        cmd.trial_init = 1'b1;
      end
      ST_ROT: cmd.rotate = 1'b1;
      ST_WB: begin
        cmd.rotate = 1'b1;
        cmd.we_a = 1'b1;
        cmd.we_b = 1'b1;
      end
      ST_RESULT: cmd.out_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clear_both <= 1'b1;
      cnt <= '0;
      line_cells <= LINE_CELLS_RESET;
      sub <= '0;
      proc <= '0;
      odd <= 1'b0;
      sel <= 1'b0;
      out_valid <= 1'b0;
      step <= '0;
      back <= '0;
      fore <= '0;
      commit <= 1'b0;
      done_l <= 1'b0;
      column_l <= '0;
    end else begin
      if (cfg_write) line_cells <= cfg_data;
      if (state == ST_RESULT && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          if (cnt == AW'(DEPTH - 1)) begin
            cnt <= '0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            cnt <= '0;
            if (in_frame_start) begin
              odd <= 1'b0;
              proc <= '0;
            end
            if (sub_e == 3'd7) begin
              done_l <= done_c;
              column_l <= col_c;
              state <= ST_LOAD;
            end else begin
              sub <= sub_e + 3'd1;
              if (in_frame_start) begin
                clear_both <= 1'b1;
                state <= ST_CLEAR;
              end
            end
          end
        end
        ST_LOAD: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(WIN)) begin
            back <= 4'd0;
            fore <= 4'd1;
            commit <= 1'b0;
            state <= ST_INIT;
          end
        end
        ST_INIT: begin
          step <= '0;
          state <= ST_P0;
        end
        ST_P0: state <= ST_P1;
        ST_P1: state <= ST_P2;
        ST_P2: state <= ST_P3;
        ST_P3: begin
          if (step == 3'(STEPS - 1)) begin
            cnt <= '0;
            state <= commit ? ST_ROT : ST_TEND;
          end else begin
            step <= step + 3'd1;
            state <= ST_P0;
          end
        end
        ST_TEND: begin
          step <= '0;
          state <= ST_P0;
          if (back == PAIR_LAST_BACK && fore == PAIR_LAST_FORE) begin
            commit <= 1'b1;
          end else if (fore == 4'd15) begin
            back <= back + 4'd1;
            fore <= back + 4'd2;
          end else begin
            fore <= fore + 4'd1;
          end
        end
        // two more turns bring the window back to its loaded order
        ST_ROT: begin
          if (cnt == AW'(1)) begin
            cnt <= '0;
            state <= ST_WB;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_WB: begin
          cnt <= cnt + 1'b1;
          if (cnt == AW'(WIN - 1)) state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            sub <= '0;
            cnt <= '0;
            if (done_l) begin
              proc <= '0;
              odd <= !odd;
              sel <= !sel;
              clear_both <= 1'b0;
              state <= ST_CLEAR;
            end else begin
              proc <= proc + 1'b1;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/cpdq_datapath.sv
// datapath: cell buffer, error rows, trial dither arithmetic, best pair and result register
module cpdq_datapath import cpdq_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 512,
  localparam int DEPTH = MAX_LINE_WIDTH + 2,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  cpdq_cmd_t     cmd,
  input  logic [AW-1:0] raddr,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    in_red,
  input  logic [7:0]    in_green,
  input  logic [7:0]    in_blue,
  output logic [7:0]    bitmap_byte,
  output logic [7:0]    colour_byte,
  output logic [5:0]    cell_column,
  output logic          line_done,
  output logic [28:0]   cell_error
);

  localparam int EW = 3 * ERR_W;

  rgb_t        cell_buf [STEPS];
  comp_t       orig_cur [WIN][3];
  comp_t       orig_nxt [WIN][3];
  comp_t       work_cur [WIN][3];
  comp_t       work_nxt [WIN][3];
  diff_t       eb [3];
  diff_t       ef [3];
  logic [15:0] sqb [3];
  logic [15:0] sqf [3];
  logic [25:0] d0;
  logic [25:0] d1;
  logic [28:0] acc_sum;
  logic [7:0]  acc_bits;
  logic [28:0] best_sum;
  logic [7:0]  best_pair;

  logic [EW-1:0] rd_a;
  logic [EW-1:0] rd_b;
  logic [EW-1:0] rd_this;
  logic [EW-1:0] rd_next;
  logic [EW-1:0] wd_this;
  logic [EW-1:0] wd_next;
  logic [EW-1:0] wd_a;
  logic [EW-1:0] wd_b;

  rgb_t              px;
  logic [3:0]        pb;
  logic [3:0]        pf;
  rgb_t              pal_b;
  rgb_t              pal_f;
  logic signed [10:0] t_pix [3];
  logic [7:0]        v [3];
  diff_t             eb_n [3];
  diff_t             ef_n [3];
  logic              pick;
  diff_t             ep [3];
  comp_t             upd_cur [WIN][3];
  comp_t             upd_nxt [WIN][3];
  comp_t             rot_cur [WIN][3];
  comp_t             rot_nxt [WIN][3];

  assign rd_this = cmd.sel ? rd_b : rd_a;
  assign rd_next = cmd.sel ? rd_a : rd_b;
  assign wd_this = cmd.wzero ? '0 : {work_cur[0][0], work_cur[0][1], work_cur[0][2]};
  assign wd_next = cmd.wzero ? '0 : {work_nxt[0][0], work_nxt[0][1], work_nxt[0][2]};
  assign wd_a = cmd.sel ? wd_next : wd_this;
  assign wd_b = cmd.sel ? wd_this : wd_next;

  cpdq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_a (
    .clk(clk), .we(cmd.we_a), .waddr(waddr), .wdata(wd_a), .raddr(raddr), .rdata(rd_a)
  );

  cpdq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram_b (
    .clk(clk), .we(cmd.we_b), .waddr(waddr), .wdata(wd_b), .raddr(raddr), .rdata(rd_b)
  );

  // step front end: error-adjusted pixel and its offsets from both colours
  always_comb begin
    px = cell_buf[cmd.rd_pos];
    pb = cmd.commit ? best_pair[7:4] : cmd.back;
    pf = cmd.commit ? best_pair[3:0] : cmd.fore;
    pal_b = PALETTE[pb];
    pal_f = PALETTE[pf];
    for (int c = 0; c < 3; c++) begin
      t_pix[c] = signed'({3'b000, px[c]}) + 11'(cpdq_round16(work_cur[1][c]));
      v[c] = cpdq_sat8(t_pix[c]);
      eb_n[c] = signed'({1'b0, v[c]}) - signed'({1'b0, pal_b[c]});
      ef_n[c] = signed'({1'b0, v[c]}) - signed'({1'b0, pal_f[c]});
    end
  end

  // window kept in processing order: slot 1 is the current pixel, slot 2 the one ahead
  always_comb begin
    pick = d1 < d0;
    for (int c = 0; c < 3; c++) ep[c] = pick ? ef[c] : eb[c];
    for (int i = 0; i < WIN; i++) begin
      for (int c = 0; c < 3; c++) begin
        upd_cur[i][c] = work_cur[i][c];
        upd_nxt[i][c] = work_nxt[i][c];
      end
    end
    if (cmd.ph3) begin
      for (int c = 0; c < 3; c++) begin
        upd_cur[2][c] = work_cur[2][c] + ERR_W'(ep[c]) * 13'sd7;
        upd_nxt[2][c] = work_nxt[2][c] + ERR_W'(ep[c]);
        upd_nxt[1][c] = work_nxt[1][c] + ERR_W'(ep[c]) * 13'sd5;
        upd_nxt[0][c] = work_nxt[0][c] + ERR_W'(ep[c]) * 13'sd3;
      end
    end
    for (int i = 0; i < WIN; i++) begin
      for (int c = 0; c < 3; c++) begin
        rot_cur[i][c] = upd_cur[(i + 1) % WIN][c];
        rot_nxt[i][c] = upd_nxt[(i + 1) % WIN][c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_we) cell_buf[cmd.pix_pos] <= {in_red, in_green, in_blue};

    if (cmd.load_shift) begin
      for (int i = 0; i < WIN - 1; i++) begin
        orig_cur[i] <= orig_cur[i + 1];
        orig_nxt[i] <= orig_nxt[i + 1];
      end
      orig_cur[WIN-1][0] <= rd_this[EW-1:2*ERR_W];
      orig_cur[WIN-1][1] <= rd_this[2*ERR_W-1:ERR_W];
      orig_cur[WIN-1][2] <= rd_this[ERR_W-1:0];
      orig_nxt[WIN-1][0] <= rd_next[EW-1:2*ERR_W];
      orig_nxt[WIN-1][1] <= rd_next[2*ERR_W-1:ERR_W];
      orig_nxt[WIN-1][2] <= rd_next[ERR_W-1:0];
    end

    if (cmd.trial_init) begin
      work_cur <= orig_cur;
      work_nxt <= orig_nxt;
      acc_sum <= '0;
      acc_bits <= '0;
    end else if (cmd.ph3 || cmd.rotate) begin
      work_cur <= rot_cur;
      work_nxt <= rot_nxt;
    end

    if (cmd.ph0) begin
      eb <= eb_n;
      ef <= ef_n;
    end

    if (cmd.ph1) begin
      for (int c = 0; c < 3; c++) begin
        sqb[c] <= 16'(cpdq_abs(eb[c])) * 16'(cpdq_abs(eb[c]));
        sqf[c] <= 16'(cpdq_abs(ef[c])) * 16'(cpdq_abs(ef[c]));
      end
    end

    if (cmd.ph2) begin
      d0 <= 26'(sqb[0]) * 26'(W_RED) + 26'(sqb[1]) * 26'(W_GREEN)
          + 26'(sqb[2]) * 26'(W_BLUE);
      d1 <= 26'(sqf[0]) * 26'(W_RED) + 26'(sqf[1]) * 26'(W_GREEN)
          + 26'(sqf[2]) * 26'(W_BLUE);
    end

    if (cmd.ph3) begin
      acc_sum <= acc_sum + 29'(pick ? d1 : d0);
      acc_bits[~cmd.rd_pos] <= pick;
    end

    if (cmd.best_upd && (cmd.best_first || acc_sum < best_sum)) begin
      best_sum <= acc_sum;
      best_pair <= {cmd.back, cmd.fore};
    end

    if (cmd.out_load) begin
      bitmap_byte <= acc_bits;
      colour_byte <= best_pair;
      cell_column <= cmd.column;
      line_done <= cmd.line_done;
      cell_error <= acc_sum;
    end
  end

endmodule

// File: rtl/core/cpdq_checker.sv
// port level checks of the quantizer and their bind
module cpdq_checker (
  input logic        clk,
  input logic        rst,
  input logic        pix_valid,
  input logic        pix_ready,
  input logic        pix_frame_start,
  input logic        cell_valid,
  input logic        cell_ready,
  input logic [7:0]  colour_byte,
  input logic [28:0] cell_error
);

  // a held result beat keeps its colour byte and cell error
  a_hold: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_ready |=> cell_valid && $stable(colour_byte) && $stable(cell_error))
    else $error("result beat changed while stalled");

  // back index is always below fore index
  a_pair: assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> colour_byte[7:4] < colour_byte[3:0])
    else $error("colour pair out of order");

  a_bound: assert property (@(posedge clk) disable iff (rst)
    cell_valid |-> cell_error <= 29'd520200000)
    else $error("cell error above its bound");

  // reset starts the clearing pass
  a_rst_clear: assert property (@(posedge clk) rst |=> !pix_ready)
    else $error("pixel taken during reset clear");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    pix_valid && pix_ready && pix_frame_start |=> !pix_ready)
    else $error("pixel taken during frame clear");

endmodule

bind cell_pair_dither_quantizer cpdq_checker u_cpdq_checker (
  .clk(clk),
  .rst(rst),
  .pix_valid(pixel.valid),
  .pix_ready(pixel.ready),
  .pix_frame_start(pixel.frame_start),
  .cell_valid(result.valid),
  .cell_ready(result.ready),
  .colour_byte(result.colour_byte),
  .cell_error(result.cell_error)
);
